@@ rtl/core/srst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seam row shift table package
// Shared types and constants for the seam row shift table block.
// ----------------------------------------------------------------------------
package srst_pkg;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned IDX_W   = 8;
   localparam int unsigned COORD_W = 12;
   localparam int unsigned RANGE_W = 9;
   localparam int unsigned SHOUT_W = 14;
   localparam int unsigned SHIFT_W = 13;
   localparam int unsigned CSR_W   = 10;

   // Table depth and image width; the field widths above are sized for these.
   localparam int unsigned MAX_SEAMS = 256;
   localparam int unsigned MAX_WIDTH = 4096;

   localparam logic [COORD_W-1:0] COL_MAX = COORD_W'(MAX_WIDTH - 1);

   localparam logic [SHIFT_W-1:0] SHIFT_LO = 13'h1000;
   localparam logic [SHIFT_W-1:0] SHIFT_HI = 13'h0FFF;

   localparam logic CSR_SEAM_COUNT   = 1'b0;
   localparam logic CSR_CARVED_COUNT = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 3'd0,
      OP_READ    = 3'd1,
      OP_CLEAR   = 3'd2,
      OP_PREPARE = 3'd3,
      OP_RESTORE = 3'd4,
      OP_LSHIFT  = 3'd5,
      OP_RSHIFT  = 3'd6,
      OP_IRSHIFT = 3'd7
   } op_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_OUTER_RD,   // read coord of outer seam
      ST_OUTER_WT,   // capture outer coord
      ST_INNER_RD,   // read coord/shift of inner seam
      ST_INNER_WT,   // compare and write back
      ST_SELF,       // irshift self increment read
      ST_SELF_WT,
      ST_READ_WT,
      ST_RESP
   } state_type;

   // Saturating add of -1 or +1 on a shift value.
   function automatic logic [SHIFT_W-1:0] sat_step(input logic [SHIFT_W-1:0] v,
                                                   input logic up);
      logic [SHIFT_W-1:0] r;
      begin
         if (up) r = (v == SHIFT_HI) ? v : v + 1'b1;
         else    r = (v == SHIFT_LO) ? v : v - 1'b1;
         return r;
      end
   endfunction

endpackage

@@ rtl/core/srst_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seam table request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface srst_req_if;
   logic                          valid;
   logic                          ready;
   logic [srst_pkg::OP_W-1:0]     operation;
   logic [srst_pkg::IDX_W-1:0]    entry_index;
   logic [srst_pkg::COORD_W-1:0]  coord_value;
   logic [srst_pkg::RANGE_W-1:0]  range_first;
   logic [srst_pkg::RANGE_W-1:0]  range_last;

   modport source (output valid, operation, entry_index, coord_value, range_first,
                   range_last, input ready);
   modport sink (input valid, operation, entry_index, coord_value, range_first,
                 range_last, output ready);
endinterface

interface srst_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [srst_pkg::COORD_W-1:0]        coord_out;
   logic signed [srst_pkg::SHOUT_W-1:0] shift_out;
   logic                                done_res;

   modport source (output valid, coord_out, shift_out, done_res, input ready);
   modport sink (input valid, coord_out, shift_out, done_res, output ready);
endinterface

@@ rtl/core/srst_tables.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seam table storage
// Coordinate and shift memories, one port each, registered read data.
// ----------------------------------------------------------------------------
module srst_tables #(
   parameter int unsigned AW = 8
) (
   input  logic                           clock,
   input  logic [AW-1:0]                  addr,
   input  logic                           coord_we,
   input  logic [srst_pkg::COORD_W-1:0]   coord_wdata,
   input  logic                           shift_we,
   input  logic [srst_pkg::SHIFT_W-1:0]   shift_wdata,
   output logic [srst_pkg::COORD_W-1:0]   coord_rdata,
   output logic [srst_pkg::SHIFT_W-1:0]   shift_rdata
);

   logic [srst_pkg::COORD_W-1:0] coord_mem [2**AW];
   logic [srst_pkg::SHIFT_W-1:0] shift_mem [2**AW];

   // Coordinate memory.
   always_ff @(posedge clock) begin
      if (coord_we) begin
         coord_mem[addr] <= coord_wdata;
      end
      coord_rdata <= coord_mem[addr];
   end

   // Shift memory.
   always_ff @(posedge clock) begin
      if (shift_we) begin
         shift_mem[addr] <= shift_wdata;
      end
      shift_rdata <= shift_mem[addr];
   end

endmodule

@@ rtl/core/seam_row_shift_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seam row shift table
// Prepare, restore and range shifts walk seam pairs: each outer seam against
// the inner seams. One word at a time; the next can be taken in the cycle
// after the response is accepted. After reset a clearing pass zeroes the
// shift table before the first word is accepted.
// ----------------------------------------------------------------------------
module seam_row_shift_table (
   input  logic                          clock,
   input  logic                          reset,
   srst_req_if.sink                      req,
   srst_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [srst_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int unsigned AW = $clog2(srst_pkg::MAX_SEAMS);
   localparam int unsigned CW = AW + 1;
   localparam logic [CW-1:0] NMAX = CW'(srst_pkg::MAX_SEAMS);

   srst_pkg::state_type state_ff, state_in;

   logic [8:0]  seam_count_ff;
   logic signed [9:0] carved_ff;
   logic [srst_pkg::OP_W-1:0] op_ff;
   logic [CW-1:0] a_ff, a_in, b_ff, b_in, end_ff, end_in, n_ff, n_in;
   logic          phase_ff, phase_in;   // restore: 0 coord pass, 1 shift pass
   logic [srst_pkg::COORD_W-1:0] s_ff, s_in;
   logic [srst_pkg::COORD_W-1:0] cout_ff, cout_in;
   logic [srst_pkg::SHIFT_W-1:0] sout_ff, sout_in;

   logic [AW-1:0] addr;
   logic coord_we, shift_we;
   logic [srst_pkg::COORD_W-1:0] coord_wdata, coord_rdata;
   logic [srst_pkg::SHIFT_W-1:0] shift_wdata, shift_rdata;

   srst_tables #(.AW(AW)) u_tables (
      .clock, .addr, .coord_we, .coord_wdata, .shift_we, .shift_wdata,
      .coord_rdata, .shift_rdata
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seam_count_ff <= '0;
         carved_ff     <= '0;
      end else if (csr_we) begin
         if (csr_index == srst_pkg::CSR_SEAM_COUNT) seam_count_ff <= csr_wdata[8:0];
         else carved_ff <= csr_wdata;
      end
   end

   logic [CW-1:0] active_n;
   logic [CW-1:0] carved_mag;
   logic [CW-1:0] last_sat;
   logic [9:0]    carved_abs;
   always_comb begin
      active_n = (32'(seam_count_ff) > 32'(srst_pkg::MAX_SEAMS)) ? NMAX
                                                                 : CW'(seam_count_ff);
      carved_abs = carved_ff[9] ? 10'(-carved_ff) : 10'(carved_ff);
      carved_mag = (32'(carved_abs) > 32'(srst_pkg::MAX_SEAMS)) ? NMAX : CW'(carved_abs);
      last_sat   = (32'(req.range_last) > 32'(srst_pkg::MAX_SEAMS)) ? NMAX
                                                                    : CW'(req.range_last);
   end

   // Op is a shift-range kind (including restore's second pass).
   logic is_range, dir_up, self_inc;
   always_comb begin
      is_range = (op_ff == srst_pkg::OP_LSHIFT) || (op_ff == srst_pkg::OP_RSHIFT) ||
                 (op_ff == srst_pkg::OP_IRSHIFT) ||
                 ((op_ff == srst_pkg::OP_RESTORE) && phase_ff);
      dir_up   = (op_ff == srst_pkg::OP_RSHIFT) || (op_ff == srst_pkg::OP_IRSHIFT) ||
                 ((op_ff == srst_pkg::OP_RESTORE) && carved_ff[9]);
      self_inc = (op_ff == srst_pkg::OP_IRSHIFT);
   end

   // State register and sequencer data.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srst_pkg::ST_CLEAR;
         a_ff     <= '0;
         op_ff    <= srst_pkg::OP_READ;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         a_ff     <= a_in;
         phase_ff <= phase_in;
         if (req.valid && req.ready) op_ff <= req.operation;
      end
      b_ff <= b_in; end_ff <= end_in; n_ff <= n_in;
      s_ff <= s_in; cout_ff <= cout_in; sout_ff <= sout_in;
   end

   // Next state and memory control.
   always_comb begin
      state_in = state_ff; a_in = a_ff; b_in = b_ff; end_in = end_ff; n_in = n_ff;
      phase_in = phase_ff; s_in = s_ff; cout_in = cout_ff; sout_in = sout_ff;
      addr = a_ff[AW-1:0];
      coord_we = 1'b0; coord_wdata = coord_rdata;
      shift_we = 1'b0; shift_wdata = '0;
      req.ready = 1'b0;
      case (state_ff)
         srst_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            addr = req.entry_index[AW-1:0];
            cout_in = '0; sout_in = '0; n_in = active_n; phase_in = 1'b0;
            if (req.valid) begin
               case (req.operation)
                  srst_pkg::OP_WRITE: begin
                     if (32'(req.entry_index) < 32'(srst_pkg::MAX_SEAMS)) begin
                        coord_we = 1'b1;
                        coord_wdata = (req.coord_value > srst_pkg::COL_MAX) ?
                                      srst_pkg::COL_MAX : req.coord_value;
                     end
                     state_in = srst_pkg::ST_RESP;
                  end
                  srst_pkg::OP_READ: begin
                     state_in = (32'(req.entry_index) < 32'(srst_pkg::MAX_SEAMS)) ?
                                srst_pkg::ST_READ_WT : srst_pkg::ST_RESP;
                  end
                  srst_pkg::OP_CLEAR: begin
                     a_in = '0; state_in = srst_pkg::ST_CLEAR;
                  end
                  srst_pkg::OP_PREPARE: begin
                     a_in = '0; end_in = active_n; state_in = srst_pkg::ST_OUTER_RD;
                  end
                  srst_pkg::OP_RESTORE: begin
                     a_in = active_n; end_in = active_n; state_in = srst_pkg::ST_OUTER_RD;
                  end
                  default: begin
                     a_in = CW'(req.range_first); end_in = last_sat;
                     state_in = srst_pkg::ST_OUTER_RD;
                  end
               endcase
            end
         end
         srst_pkg::ST_READ_WT: begin
            cout_in = coord_rdata; sout_in = shift_rdata;
            state_in = srst_pkg::ST_RESP;
         end
         srst_pkg::ST_CLEAR: begin
            // The clearing pass after reset ends silently; a clear word answers.
            shift_we = 1'b1;
            a_in = a_ff + 1'b1;
            if (a_ff == NMAX - 1'b1) begin
               state_in = (op_ff == srst_pkg::OP_CLEAR) ? srst_pkg::ST_RESP
                                                        : srst_pkg::ST_IDLE;
            end
         end
         srst_pkg::ST_OUTER_RD: begin
            // Outer loop test and issue read of outer seam.
            if (op_ff == srst_pkg::OP_RESTORE && !phase_ff) begin
               if (a_ff == '0) begin
                  phase_in = 1'b1; a_in = '0; end_in = carved_mag;
               end else begin
                  addr = AW'(a_ff - 1'b1);
                  state_in = srst_pkg::ST_OUTER_WT;
               end
            end else if (a_ff >= end_ff) begin
               state_in = srst_pkg::ST_RESP;
            end else begin
               addr = a_ff[AW-1:0];
               state_in = srst_pkg::ST_OUTER_WT;
            end
         end
         srst_pkg::ST_OUTER_WT: begin
            s_in = coord_rdata;
            if (op_ff == srst_pkg::OP_PREPARE) begin
               shift_we = 1'b1; b_in = a_ff + 1'b1;
            end else if (op_ff == srst_pkg::OP_RESTORE && !phase_ff) begin
               b_in = a_ff;
            end else begin
               b_in = '0;
            end
            state_in = srst_pkg::ST_INNER_RD;
         end
         srst_pkg::ST_INNER_RD: begin
            addr = b_ff[AW-1:0];
            if (b_ff >= n_ff) begin
               addr = a_ff[AW-1:0];
               if (self_inc) state_in = srst_pkg::ST_SELF;
               else begin
                  state_in = srst_pkg::ST_OUTER_RD;
                  a_in = (op_ff == srst_pkg::OP_RESTORE && !phase_ff) ? a_ff - 1'b1
                                                                      : a_ff + 1'b1;
               end
            end else begin
               state_in = srst_pkg::ST_INNER_WT;
            end
         end
         srst_pkg::ST_INNER_WT: begin
            addr = b_ff[AW-1:0];
            shift_wdata = srst_pkg::sat_step(shift_rdata, dir_up);
            if (is_range) begin
               shift_we = (coord_rdata > s_ff);
            end else if (op_ff == srst_pkg::OP_PREPARE) begin
               coord_we = (coord_rdata >= s_ff) && (coord_rdata != '0);
               coord_wdata = coord_rdata - 1'b1;
            end else begin
               coord_we = (coord_rdata >= s_ff) && (coord_rdata < srst_pkg::COL_MAX);
               coord_wdata = coord_rdata + 1'b1;
            end
            b_in = b_ff + 1'b1;
            state_in = srst_pkg::ST_INNER_RD;
         end
         srst_pkg::ST_SELF: begin
            state_in = srst_pkg::ST_SELF_WT;
         end
         srst_pkg::ST_SELF_WT: begin
            shift_we = 1'b1;
            shift_wdata = srst_pkg::sat_step(shift_rdata, 1'b1);
            a_in = a_ff + 1'b1;
            state_in = srst_pkg::ST_OUTER_RD;
         end
         srst_pkg::ST_RESP: begin
            if (rsp.ready) state_in = srst_pkg::ST_IDLE;
         end
         default: state_in = srst_pkg::ST_IDLE;
      endcase
   end

   assign rsp.valid     = (state_ff == srst_pkg::ST_RESP);
   assign rsp.coord_out = cout_ff;
   assign rsp.shift_out = {sout_ff[srst_pkg::SHIFT_W-1], sout_ff};
   assign rsp.done_res  = 1'b1;

   // The request side is closed while a result waits.
   a_no_ready_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("ready during response");
   // An accepted word always leaves the idle state.
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff != srst_pkg::ST_IDLE)
      else $error("accept without start");
   // A taken response returns to idle.
   a_resp_done: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready) |=> state_ff == srst_pkg::ST_IDLE)
      else $error("response not retired");

endmodule
